// ----- rtl/m4alu_pkg.sv -----
// ----------------------------------------------------------------------------
// m4alu_pkg
// Shared constants, field layout, operation codes and the saturation helper
// for the fixed-point 4x4 matrix unit.
// ----------------------------------------------------------------------------
package m4alu_pkg;

   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int CELLS     = DIM * DIM;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int DIM_W     = $clog2(DIM);

   // fixed field widths
   localparam int DATA_W = 32;
   localparam int IDX_W  = 4;
   localparam int OP_W   = 3;
   localparam int EPS_W  = 16;

   // arithmetic widths
   localparam int PROD_W   = 2 * DATA_W;
   localparam int NUM_W    = DATA_W + FRAC_BITS;
   localparam int DIVCNT_W = $clog2(NUM_W);
   localparam int ACC_W    = PROD_W - FRAC_BITS + $clog2(DIM) + 1;

   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // stream packing
   localparam int REQ_IDX_LO   = 0;
   localparam int REQ_A_LO     = REQ_IDX_LO + IDX_W;
   localparam int REQ_B_LO     = REQ_A_LO + DATA_W;
   localparam int REQ_OP_LO    = REQ_B_LO + DATA_W;
   localparam int REQ_S_LO     = REQ_OP_LO + OP_W;
   localparam int REQ_TDATA_W  = ((REQ_S_LO + DATA_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((IDX_W + DATA_W + 7) / 8) * 8;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD       = 3'd0,
      OP_SUB       = 3'd1,
      OP_MUL       = 3'd2,
      OP_SCALE     = 3'd3,
      OP_DIV       = 3'd4,
      OP_TRANSPOSE = 3'd5
   } op_type;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_EPS_WORD = '0;
   localparam logic [EPS_W-1:0]      EPS_RESET    = 16'd1;

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-DATA_W:0] top;
      top = v[ACC_W-1:DATA_W-1];
      if ((&top) || !(|top)) begin
         return v[DATA_W-1:0];
      end else begin
         return v[ACC_W-1] ? DATA_MIN : DATA_MAX;
      end
   endfunction

endpackage

// ----- rtl/matrix4_fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// matrix4_fixed_point_alu
// 4x4 Q16.16 matrix unit: loads A and B one element pair per item, runs
// add, subtract, product, scale, divide or transpose, streams 16 results.
// ----------------------------------------------------------------------------
//  channel | direction | ports                           | carries
//  req     | in        | req_tvalid/tready/tdata/tuser   | load or run item
//  rsp     | out       | rsp_tvalid/tready/tdata/tuser/tlast | one result element
//  csr     | in/out    | csr_psel/penable/pwrite/paddr/..| epsilon_threshold
//
//  a load item is written to the stores when it is taken; a run item holds
//  req_tready low until its sixteenth result is taken. per element, after the
//  result is taken: add, subtract, transpose and skipped divide go READ, EXEC,
//  OUT; scale adds ACC; multiply repeats READ, EXEC, ACC once per term (one pass
//  of the shared multiplier per term); divide runs ST_DIV (a restoring divider
//  that resolves one quotient bit per cycle over 48 bits), then DIV_FIN, OUT.
//  reset is synchronous and clears the sequencer and the epsilon register (to 1);
//  the matrix stores are not cleared. rsp back-pressure stalls the run.
module matrix4_fixed_point_alu (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // element_index[3:0], a_value[35:4], b_value[67:36], operation[70:68],
   // scalar[102:71], zero pad[103]
   input  logic [m4alu_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // kind[0]
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // result_index[3:0], result_value[35:4], zero pad[39:36]
   output logic [m4alu_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // divide_skipped[0]
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [m4alu_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [m4alu_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [m4alu_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);
   import m4alu_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_ACC,
      ST_DIV,
      ST_DIV_FIN,
      ST_OUT
   } state_type;

   // input unpacking
   logic [IDX_W-1:0]         req_idx;
   logic signed [DATA_W-1:0] req_a;
   logic signed [DATA_W-1:0] req_b;
   logic [OP_W-1:0]          req_op;
   logic signed [DATA_W-1:0] req_scalar;
   logic [DATA_W-1:0]        req_mag;
   logic                     req_fire;
   logic                     load_hit;
   logic                     run_ok;

   assign req_idx    = req_tdata[REQ_IDX_LO +: IDX_W];
   assign req_a      = req_tdata[REQ_A_LO +: DATA_W];
   assign req_b      = req_tdata[REQ_B_LO +: DATA_W];
   assign req_op     = req_tdata[REQ_OP_LO +: OP_W];
   assign req_scalar = req_tdata[REQ_S_LO +: DATA_W];
   assign req_mag    = req_scalar[DATA_W-1] ? (~req_scalar + 1'b1) : req_scalar;

   assign req_fire = req_tvalid && req_tready;
   assign load_hit = req_fire && (req_tuser == KIND_LOAD) && (int'(req_idx) < CELLS);
   assign run_ok   = req_fire && (req_tuser == KIND_RUN) && (req_op <= OP_TRANSPOSE);

   // registers
   state_type                state_ff,    state_in;
   logic [EPS_W-1:0]         eps_ff,      eps_in;
   op_type                   op_ff,       op_in;
   logic signed [DATA_W-1:0] scalar_ff,   scalar_in;
   logic [DATA_W-1:0]        den_ff,      den_in;
   logic                     skip_ff,     skip_in;
   logic [ADDR_W-1:0]        i_ff,        i_in;
   logic [DIM_W-1:0]         row_ff,      row_in;
   logic [DIM_W-1:0]         col_ff,      col_in;
   logic [DIM_W-1:0]         k_ff,        k_in;
   logic signed [ACC_W-1:0]  acc_ff,      acc_in;
   logic signed [PROD_W-1:0] prod_ff,     prod_in;
   logic [NUM_W-1:0]         div_num_ff,  div_num_in;
   logic [DATA_W-1:0]        div_rem_ff,  div_rem_in;
   logic [DIVCNT_W-1:0]      div_cnt_ff,  div_cnt_in;
   logic                     div_neg_ff,  div_neg_in;
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;

   // matrix stores
   logic signed [DATA_W-1:0] mat_a_mem [CELLS];
   logic signed [DATA_W-1:0] mat_b_mem [CELLS];
   logic signed [DATA_W-1:0] a_rd_ff;
   logic signed [DATA_W-1:0] b_rd_ff;
   logic [ADDR_W-1:0]        a_addr;
   logic [ADDR_W-1:0]        b_addr;

   always_comb begin
      case (op_ff)
         OP_MUL: begin
            a_addr = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(DIM)) + ADDR_W'(k_ff);
            b_addr = ADDR_W'(ADDR_W'(k_ff) * ADDR_W'(DIM)) + ADDR_W'(col_ff);
         end
         OP_TRANSPOSE: begin
            a_addr = ADDR_W'(ADDR_W'(col_ff) * ADDR_W'(DIM)) + ADDR_W'(row_ff);
            b_addr = i_ff;
         end
         default: begin
            a_addr = i_ff;
            b_addr = i_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         mat_a_mem[ADDR_W'(req_idx)] <= req_a;
         mat_b_mem[ADDR_W'(req_idx)] <= req_b;
      end
      a_rd_ff <= mat_a_mem[a_addr];
      b_rd_ff <= mat_b_mem[b_addr];
   end

   // shared multiplier and rounding
   logic signed [DATA_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_mul;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [PROD_W-1:0] prod_shr;
   logic signed [ACC_W-1:0]  fx_term;
   logic signed [ACC_W-1:0]  acc_sum;
   logic signed [ACC_W-1:0]  add_sum;
   logic signed [ACC_W-1:0]  sub_diff;

   assign mul_b    = (op_ff == OP_SCALE) ? scalar_ff : b_rd_ff;
   assign prod_mul = a_rd_ff * mul_b;
   assign prod_rnd = prod_ff + RND_HALF;
   assign prod_shr = prod_rnd >>> FRAC_BITS;
   assign fx_term  = ACC_W'(prod_shr);
   assign acc_sum  = acc_ff + fx_term;
   assign add_sum  = ACC_W'(a_rd_ff) + ACC_W'(b_rd_ff);
   assign sub_diff = ACC_W'(a_rd_ff) - ACC_W'(b_rd_ff);

   // divider step
   logic [DATA_W-1:0] mag_a;
   logic [DATA_W:0]   rem_shift;
   logic [DATA_W:0]   den_ext;
   logic              rem_ge;
   logic [DATA_W:0]   rem_sub;
   logic              q_big;

   assign mag_a     = a_rd_ff[DATA_W-1] ? (~a_rd_ff + 1'b1) : a_rd_ff;
   assign rem_shift = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign den_ext   = {1'b0, den_ff};
   assign rem_ge    = rem_shift >= den_ext;
   assign rem_sub   = rem_shift - den_ext;
   assign q_big     = |div_num_ff[NUM_W-1:DATA_W-1];

   // csr
   logic                  csr_wr;
   logic [CSR_ADDR_W-3:0] csr_word;

   assign csr_pready = 1'b1;
   assign csr_word   = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_word == CSR_EPS_WORD) ? CSR_DATA_W'(eps_ff) : '0;

   logic last_elem;
   assign last_elem = (i_ff == ADDR_W'(CELLS - 1));

   always_comb begin
      state_in     = state_ff;
      eps_in       = eps_ff;
      op_in        = op_ff;
      scalar_in    = scalar_ff;
      den_in       = den_ff;
      skip_in      = skip_ff;
      i_in         = i_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_cnt_in   = div_cnt_ff;
      div_neg_in   = div_neg_ff;
      out_value_in = out_value_ff;

      if (csr_wr && (csr_word == CSR_EPS_WORD)) begin
         eps_in = csr_pwdata[EPS_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (run_ok) begin
               op_in     = op_type'(req_op);
               scalar_in = req_scalar;
               den_in    = req_mag;
               skip_in   = (req_op == OP_DIV) && (req_mag <= DATA_W'(eps_ff));
               i_in      = '0;
               row_in    = '0;
               col_in    = '0;
               k_in      = '0;
               acc_in    = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_ADD: begin
                  out_value_in = sat_data(add_sum);
                  state_in     = ST_OUT;
               end
               OP_SUB: begin
                  out_value_in = sat_data(sub_diff);
                  state_in     = ST_OUT;
               end
               OP_MUL, OP_SCALE: begin
                  prod_in  = prod_mul;
                  state_in = ST_ACC;
               end
               OP_DIV: begin
                  if (skip_ff) begin
                     out_value_in = a_rd_ff;
                     state_in     = ST_OUT;
                  end else begin
                     // round to nearest by adding half the divisor up front
                     div_num_in = {mag_a, FRAC_BITS'(0)} + NUM_W'(den_ff >> 1);
                     div_rem_in = '0;
                     div_cnt_in = DIVCNT_W'(NUM_W - 1);
                     div_neg_in = a_rd_ff[DATA_W-1] ^ scalar_ff[DATA_W-1];
                     state_in   = ST_DIV;
                  end
               end
               OP_TRANSPOSE: begin
                  out_value_in = a_rd_ff;
                  state_in     = ST_OUT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_ACC: begin
            if (op_ff == OP_SCALE) begin
               out_value_in = sat_data(fx_term);
               state_in     = ST_OUT;
            end else if (k_ff == DIM_W'(DIM - 1)) begin
               out_value_in = sat_data(acc_sum);
               state_in     = ST_OUT;
            end else begin
               acc_in   = acc_sum;
               k_in     = k_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            div_rem_in = rem_ge ? rem_sub[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            div_num_in = {div_num_ff[NUM_W-2:0], rem_ge};
            if (div_cnt_ff == '0) begin
               state_in = ST_DIV_FIN;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         ST_DIV_FIN: begin
            if (div_neg_ff) begin
               out_value_in = q_big ? DATA_MIN : -signed'(div_num_ff[DATA_W-1:0]);
            end else begin
               out_value_in = q_big ? DATA_MAX : signed'(div_num_ff[DATA_W-1:0]);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in   = i_ff + 1'b1;
                  k_in   = '0;
                  acc_in = '0;
                  if (col_ff == DIM_W'(DIM - 1)) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         eps_ff   <= EPS_RESET;
      end else begin
         state_ff <= state_in;
         eps_ff   <= eps_in;
      end
      op_ff        <= op_in;
      scalar_ff    <= scalar_in;
      den_ff       <= den_in;
      skip_ff      <= skip_in;
      i_ff         <= i_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      k_ff         <= k_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      div_num_ff   <= div_num_in;
      div_rem_ff   <= div_rem_in;
      div_cnt_ff   <= div_cnt_in;
      div_neg_ff   <= div_neg_in;
      out_value_ff <= out_value_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = RSP_TDATA_W'({out_value_ff, IDX_W'(i_ff)});
   assign rsp_tuser  = skip_ff;
   assign rsp_tlast  = last_elem;

`ifndef ASSERT_OFF
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_bad_op_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == KIND_RUN) && (req_op > OP_TRANSPOSE)) |=> req_tready)
      else $error("unused operation code started a run");

   a_skip_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (op_ff == OP_DIV))
      else $error("skip flag outside a divide run");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not idle after the final result");
`endif

endmodule

// ----- bench/matrix4_fixed_point_alu_test.sv -----
// ----------------------------------------------------------------------------
// matrix4_fixed_point_alu_test
// Loads A and B element by element, starts every operation under several
// epsilon_threshold settings, and checks each result element, field by
// field, against a fixed-point prediction of the unit.
// ----------------------------------------------------------------------------
module matrix4_fixed_point_alu_test;
   timeunit 1ns;
   timeprecision 1ps;

   import m4alu_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 100;

   localparam logic [CSR_ADDR_W-1:0] EPS_ADDR   = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4);

   // operation codes that the unit ignores
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      logic              kind;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] a_value;
      logic [DATA_W-1:0] b_value;
      logic [OP_W-1:0]   operation;
      logic [DATA_W-1:0] scalar;
   } matrix_cmd_type;

   typedef struct {
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
      logic                     skipped;
      logic                     last;
   } element_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_W-1:0]     req_tdata = '0;
   logic                       req_tuser = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]     rsp_tdata;
   logic                       rsp_tuser;
   logic                       rsp_tlast;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;

   matrix_cmd_type             matrix_cmds[$];
   element_type                awaited_elements[$];
   logic signed [DATA_W-1:0]   mat_a [CELLS];
   logic signed [DATA_W-1:0]   mat_b [CELLS];
   logic [EPS_W-1:0]           eps_model = EPS_RESET;
   logic                       req_fire = 1'b0;
   logic                       quiet = 1'b0;
   int                         req_gap = 0;
   int                         rsp_hold = 0;
   int                         failures = 0;
   int                         cycle_count = 0;

   matrix4_fixed_point_alu i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // fixed-point arithmetic of the unit
   // ------------------------------------------------------------------------
   function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
      if (v > longint'(DATA_MAX)) begin
         return DATA_MAX;
      end else if (v < longint'(DATA_MIN)) begin
         return DATA_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // round to nearest, ties towards plus infinity, no saturation
   function automatic longint fx_product(input longint a, input longint b);
      return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   // round to nearest, ties away from zero
   function automatic logic signed [DATA_W-1:0] fx_quotient(input longint a,
                                                           input longint s);
      longint unsigned num;
      longint unsigned den;
      longint unsigned q;
      longint          r;
      num = magnitude(a) << FRAC_BITS;
      den = magnitude(s);
      q   = (num + den / 2) / den;
      r   = longint'(q);
      if ((a < 0) != (s < 0)) begin
         r = -r;
      end
      return clamp32(r);
   endfunction

   task automatic compute_run_elements(input logic [OP_W-1:0] op,
                                       input logic signed [DATA_W-1:0] s);
      element_type e;
      longint      acc;
      logic        skip;
      int          row;
      int          col;
      skip = (op == OP_DIV) && (magnitude(s) <= longint'(eps_model));
      for (int i = 0; i < CELLS; i++) begin
         row = i / DIM;
         col = i % DIM;
         case (op)
            OP_ADD: begin
               e.value = clamp32(longint'(mat_a[ADDR_W'(i)]) + longint'(mat_b[ADDR_W'(i)]));
            end
            OP_SUB: begin
               e.value = clamp32(longint'(mat_a[ADDR_W'(i)]) - longint'(mat_b[ADDR_W'(i)]));
            end
            OP_MUL: begin
               acc = 0;
               for (int k = 0; k < DIM; k++) begin
                  acc += fx_product(mat_a[ADDR_W'(row * DIM + k)],
                                    mat_b[ADDR_W'(k * DIM + col)]);
               end
               e.value = clamp32(acc);
            end
            OP_SCALE: begin
               e.value = clamp32(fx_product(mat_a[ADDR_W'(i)], s));
            end
            OP_DIV: begin
               e.value = skip ? mat_a[ADDR_W'(i)] : fx_quotient(mat_a[ADDR_W'(i)], s);
            end
            default: begin
               e.value = mat_a[ADDR_W'(col * DIM + row)];
            end
         endcase
         e.index   = IDX_W'(i);
         e.skipped = skip;
         e.last    = (i == CELLS - 1);
         awaited_elements.push_back(e);
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [DATA_W-1:0] corner_word(input int n);
      case (n % 16)
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return 32'h0000_0001;
         5:       return 32'h0001_0000;
         6:       return 32'hFFFF_0000;
         7:       return 32'h0001_8000;
         8:       return 32'h7FFF_0000;
         9:       return 32'h8000_0001;
         10:      return 32'h0002_0000;
         11:      return 32'hFFFE_8000;
         12:      return 32'h1234_5678;
         13:      return 32'hEDCB_A988;
         14:      return 32'h0000_8000;
         default: return 32'hFFFF_8000;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] rand_word();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom_range(0, 32'h0007_FFFF);      // within +-8.0
         4, 5:       v = $urandom();
         6:          v = corner_word($urandom_range(0, 15));
         7:          v = $urandom_range(0, 32'h01FF_FFFF);      // within +-512.0
         default:    v = $urandom_range(0, 16) << FRAC_BITS;    // whole numbers
      endcase
      if ($urandom_range(0, 1)) begin
         v = -v;
      end
      return v;
   endfunction

   // divisors cluster round the current threshold
   function automatic logic [DATA_W-1:0] rand_divisor();
      logic signed [DATA_W-1:0] d;
      case ($urandom_range(0, 4))
         0:       d = int'(eps_model) + $urandom_range(0, 2) - 1;
         1:       d = '0;
         2:       d = $urandom_range(0, 32'h0003_FFFF);
         default: d = rand_word();
      endcase
      if ($urandom_range(0, 1)) begin
         d = -d;
      end
      return d;
   endfunction

   function automatic logic [OP_W-1:0] rand_op();
      if ($urandom_range(0, 19) == 0) begin
         return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end
      return OP_W'($urandom_range(0, 5));
   endfunction

   task automatic queue_load(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] a,
                             input logic [DATA_W-1:0] b);
      matrix_cmd_type c;
      c.kind      = KIND_LOAD;
      c.index     = idx;
      c.a_value   = a;
      c.b_value   = b;
      c.operation = OP_W'($urandom_range(0, 7));
      c.scalar    = $urandom();
      matrix_cmds.push_back(c);
   endtask

   task automatic queue_run(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] s);
      matrix_cmd_type c;
      c.kind      = KIND_RUN;
      c.index     = IDX_W'($urandom_range(0, CELLS - 1));
      c.a_value   = $urandom();
      c.b_value   = $urandom();
      c.operation = op;
      c.scalar    = s;
      matrix_cmds.push_back(c);
   endtask

   // full reloads or a few rewritten elements, each followed by some runs
   task automatic queue_random(input int target);
      int               count;
      int               n;
      logic [OP_W-1:0]  op;
      count = 0;
      while (count < target) begin
         if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < CELLS; i++) begin
               queue_load(IDX_W'(i), rand_word(), rand_word());
            end
            count += CELLS;
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) queue_load(IDX_W'($urandom_range(0, CELLS - 1)), rand_word(),
                                  rand_word());
            count += n;
         end
         n = $urandom_range(1, 3);
         repeat (n) begin
            op = rand_op();
            queue_run(op, (op == OP_DIV) ? rand_divisor() : rand_word());
         end
         count += n;
      end
   endtask

   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // wait until every item is taken and every result element is in
   task automatic settle();
      do @(posedge clock);
      while (matrix_cmds.size() != 0 || req_tvalid || !req_tready ||
             awaited_elements.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      matrix_cmd_type c;
      logic [REQ_TDATA_W-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // item still on offer
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (matrix_cmds.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
         req_gap = $urandom_range(0, 17);
         req_tvalid <= 1'b0;
      end else if (matrix_cmds.size() != 0) begin
         c = matrix_cmds.pop_front();
         word = '0;
         word[REQ_IDX_LO +: IDX_W] = c.index;
         word[REQ_A_LO +: DATA_W]  = c.a_value;
         word[REQ_B_LO +: DATA_W]  = c.b_value;
         word[REQ_OP_LO +: OP_W]   = c.operation;
         word[REQ_S_LO +: DATA_W]  = c.scalar;
         req_tdata  <= word;
         req_tuser  <= c.kind;
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   always @(negedge clock) begin : rsp_stall
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         rsp_hold = $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // monitor: register model, result check, prediction of accepted items
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : observer
      element_type       want;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] got;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;

         if (csr_psel && csr_penable && csr_pready && csr_paddr == EPS_ADDR) begin
            if (csr_pwrite) begin
               eps_model = csr_pwdata[EPS_W-1:0];
            end else if (csr_prdata != CSR_DATA_W'(eps_model)) begin
               $error("epsilon_threshold: expected %0d, got %0d", eps_model, csr_prdata);
               failures++;
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            idx = rsp_tdata[0 +: IDX_W];
            got = rsp_tdata[IDX_W +: DATA_W];
            if (awaited_elements.size() == 0) begin
               $error("unexpected result element at index %0d", idx);
               failures++;
            end else begin
               want = awaited_elements.pop_front();
               if (idx != want.index) begin
                  $error("result_index: expected %0d, got %0d", want.index, idx);
                  failures++;
               end
               if (got != want.value) begin
                  $error("result_value: expected %0d, got %0d", want.value, $signed(got));
                  failures++;
               end
               if (rsp_tuser != want.skipped) begin
                  $error("divide_skipped: expected %0d, got %0d", want.skipped, rsp_tuser);
                  failures++;
               end
               if (rsp_tlast != want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_tlast);
                  failures++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            idx = req_tdata[REQ_IDX_LO +: IDX_W];
            if (req_tuser == KIND_LOAD) begin
               mat_a[idx] = req_tdata[REQ_A_LO +: DATA_W];
               mat_b[idx] = req_tdata[REQ_B_LO +: DATA_W];
            end else if (req_tdata[REQ_OP_LO +: OP_W] <= OP_TRANSPOSE) begin
               compute_run_elements(req_tdata[REQ_OP_LO +: OP_W],
                                    req_tdata[REQ_S_LO +: DATA_W]);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_access(1'b0, EPS_ADDR, '0);

      // extremes in every element, then every operation at least once
      for (int i = 0; i < CELLS; i++) begin
         queue_load(IDX_W'(i), corner_word(i), corner_word(i + 7));
      end
      queue_run(OP_ADD, $urandom());
      queue_run(OP_SUB, $urandom());
      queue_run(OP_MUL, $urandom());
      queue_run(OP_SCALE, 32'h7FFF_FFFF);
      queue_run(OP_SCALE, 32'hFFFF_8000);
      queue_run(OP_DIV, 32'h0000_0000);   // zero divisor
      queue_run(OP_DIV, 32'hFFFF_FFFF);   // magnitude equal to the threshold
      queue_run(OP_DIV, 32'h0000_0002);   // just above it, saturates
      queue_run(OP_TRANSPOSE, $urandom());
      queue_run(OP_SPARE_6, $urandom());
      queue_run(OP_SPARE_7, $urandom());
      settle();

      // zero threshold: only an exact zero is skipped
      csr_access(1'b1, EPS_ADDR, 32'hFFFF_0000);
      csr_access(1'b0, EPS_ADDR, '0);
      queue_run(OP_DIV, 32'h0000_0001);
      queue_run(OP_DIV, 32'h0000_0000);
      queue_random(75);
      settle();

      // largest threshold; the spare register slot must leave it alone
      csr_access(1'b1, EPS_ADDR, 32'h0000_FFFF);
      csr_access(1'b1, SPARE_ADDR, $urandom());
      csr_access(1'b0, EPS_ADDR, '0);
      queue_run(OP_DIV, 32'hFFFF_0001);
      queue_run(OP_DIV, 32'h0001_0000);
      queue_random(75);
      settle();

      csr_access(1'b1, EPS_ADDR, $urandom());
      csr_access(1'b0, EPS_ADDR, '0);
      queue_random(75);
      settle();

      // back to the reset value, both sides always ready
      csr_access(1'b1, EPS_ADDR, 32'h0000_0001);
      quiet <= 1'b1;
      queue_random(80);
      settle();

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
